@@ rtl/core/tfcrc_pkg.sv @@
// Shared definitions for the telemetry frame builder: frame layout, register
// indexes and the CRC-8 byte update. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfcrc_pkg;

   localparam int unsigned FRAME_BYTES = 10;
   localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;

   typedef logic [IDX_W-1:0] byte_idx_type;

   localparam byte_idx_type POS_START_ONE = byte_idx_type'(0);
   localparam byte_idx_type POS_START_TWO = byte_idx_type'(1);
   localparam byte_idx_type POS_LENGTH    = byte_idx_type'(2);
   localparam byte_idx_type POS_TAG       = byte_idx_type'(3);
   localparam byte_idx_type POS_SEQ       = byte_idx_type'(4);
   localparam byte_idx_type POS_VOLT_LO   = byte_idx_type'(5);
   localparam byte_idx_type POS_VOLT_HI   = byte_idx_type'(6);
   localparam byte_idx_type POS_CURR_LO   = byte_idx_type'(7);
   localparam byte_idx_type POS_CURR_HI   = byte_idx_type'(8);
   localparam byte_idx_type POS_CRC       = byte_idx_type'(FRAME_BYTES - 1);

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_LINK_ENABLE = csr_idx_type'(0);
   localparam csr_idx_type REG_START_ONE   = csr_idx_type'(1);
   localparam csr_idx_type REG_START_TWO   = csr_idx_type'(2);
   localparam csr_idx_type REG_LENGTH      = csr_idx_type'(3);
   localparam csr_idx_type REG_TAG         = csr_idx_type'(4);

   // MSB-first CRC-8 update of one byte, eight shift steps.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/telemetry_frame_crc8_builder.sv @@
// Telemetry frame builder: turns one voltage/current sample into a 10-byte frame
// with a CRC-8 trailer, one byte per request on the result stream. Uses tfcrc_pkg.
// Each sample is registered on acceptance; each frame byte is registered into the
// output register before it is presented. The next sample is taken in the cycle the
// CRC byte is issued, the CRC building up per byte over the length to current bytes.
// Synchronous reset clears the settings, frame state, sequence number and all valids.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_crc8_builder
   import tfcrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [31:0]           req_tdata,  // voltage_mv [15:0], current_ma [31:16]
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [7:0]            rsp_tdata,  // frame_byte [7:0]
   output      logic                  rsp_tlast   // last_byte
);

   logic               link_enable_ff;
   logic [7:0]         start_one_ff;
   logic [7:0]         start_two_ff;
   logic [7:0]         length_ff;
   logic [7:0]         tag_ff;
   logic [7:0]         seq_ff;
   logic [7:0]         seq_in;

   logic               busy_ff;
   logic               busy_in;
   byte_idx_type       idx_ff;
   byte_idx_type       idx_in;
   logic [15:0]        voltage_mv_ff;
   logic signed [15:0] current_ma_ff;
   logic [7:0]         frame_seq_ff;
   logic [7:0]         crc_ff;
   logic [7:0]         crc_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic               advance;
   logic               at_end;
   logic [7:0]         cur_byte;

   assign advance    = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign at_end     = (idx_ff == POS_CRC);
   assign req_tready = !busy_ff || (advance && at_end);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_enable_ff <= 1'b0;
         start_one_ff   <= '0;
         start_two_ff   <= '0;
         length_ff      <= '0;
         tag_ff         <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_LINK_ENABLE: link_enable_ff <= csr_wdata[0];
            REG_START_ONE:   start_one_ff   <= csr_wdata;
            REG_START_TWO:   start_two_ff   <= csr_wdata;
            REG_LENGTH:      length_ff      <= csr_wdata;
            REG_TAG:         tag_ff         <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx_ff)
         POS_START_ONE: cur_byte = start_one_ff;
         POS_START_TWO: cur_byte = start_two_ff;
         POS_LENGTH:    cur_byte = length_ff;
         POS_TAG:       cur_byte = tag_ff;
         POS_SEQ:       cur_byte = frame_seq_ff;
         POS_VOLT_LO:   cur_byte = voltage_mv_ff[7:0];
         POS_VOLT_HI:   cur_byte = voltage_mv_ff[15:8];
         POS_CURR_LO:   cur_byte = current_ma_ff[7:0];
         POS_CURR_HI:   cur_byte = current_ma_ff[15:8];
         POS_CRC:       cur_byte = crc_ff;
         default:       cur_byte = crc_ff;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         idx_in       = idx_ff + byte_idx_type'(1);
         if (idx_ff inside {[POS_LENGTH:POS_CURR_HI]}) begin
            crc_in = crc8_update(crc_ff, cur_byte);
         end
         if (at_end) begin
            busy_in = 1'b0;
         end
      end
      // Samples taken while the link is disabled are dropped.
      if (accept && link_enable_ff) begin
         busy_in = 1'b1;
         idx_in  = POS_START_ONE;
         crc_in  = CRC_INIT;
         seq_in  = seq_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= POS_START_ONE;
         crc_ff       <= CRC_INIT;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && link_enable_ff) begin
         voltage_mv_ff <= req_tdata[15:0];
         current_ma_ff <= req_tdata[31:16];
         frame_seq_ff  <= seq_ff;
      end
      if (advance) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= at_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_accept_only_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      (accept && busy_ff) |-> (advance && at_end))
      else $error("sample accepted in the middle of a frame");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= POS_CRC))
      else $error("frame byte index out of range");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("issued frame byte not held in the output register");

   a_sequence_steps: assert property (@(posedge clock) disable iff (reset)
      (accept && link_enable_ff) |=> (seq_ff == $past(seq_ff) + 8'd1))
      else $error("sequence number did not advance on a sent frame");

   a_seq_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !(accept && link_enable_ff) |=> $stable(seq_ff))
      else $error("sequence number changed without a frame");

endmodule

`default_nettype wire
